/* design/dspac_pkg.sv */
package dspac_pkg;

  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CNT_IN_W   = 16;
  localparam int unsigned ADC_IN_W   = 12;
  localparam int unsigned GAIN_W     = 22;
  localparam int unsigned MEAN_OUT_W = 12;
  localparam int unsigned MV_W       = 13;
  localparam int unsigned DUST_W     = 10;
  localparam int unsigned Q_SHIFT    = 16;
  localparam int unsigned DUST_NUM_W = 22;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_LED_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;

  localparam logic [TICK_W-1:0] LED_DELAY_RST = 16'd28;
  localparam logic [TICK_W-1:0] PERIOD_RST    = 16'd1000;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 22'd52800;

  localparam logic [MV_W-1:0] MV_MAX     = 13'd8191;
  localparam logic [MV_W-1:0] MIN_MV_RST = 13'd1000;
  localparam logic [MV_W-1:0] MAX_MV_RST = 13'd2500;
  localparam logic [MV_W-1:0] V1_OFS     = 13'd50;
  localparam logic [MV_W-1:0] V2_OFS     = 13'd200;

  localparam logic [DUST_W-1:0] DUST_MID    = 10'd500;
  localparam logic [DUST_W-1:0] DUST_MAX    = 10'd800;
  localparam logic [DUST_W-1:0] DUST_UP_MUL = 10'd3;

  typedef struct packed {
    logic                req_type;
    logic [CNT_IN_W-1:0] sample_count;
    logic [ADC_IN_W-1:0] adc_raw;
  } dspac_in_t;

  typedef struct packed {
    logic                  led_on;
    logic                  busy_res;
    logic                  done_res;
    logic [MEAN_OUT_W-1:0] mean_raw;
    logic [MV_W-1:0]       volt_mv;
    logic [DUST_W-1:0]     dust_level;
    logic [MV_W-1:0]       min_mv;
    logic [MV_W-1:0]       max_mv;
  } dspac_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } dspac_cfg_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel_dust;
    logic latch_mean;
    logic scale;
    logic sat;
    logic latch_dust;
    logic emit;
  } dspac_cmd_t;

  typedef struct packed {
    logic finish;
    logic out_free;
    logic div_done;
  } dspac_sts_t;

endpackage

/* design/dspac_chan_if.sv */
interface dspac_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/dust_sensor_pulse_average_convert.sv */
// a tick or start transfer shows its result in the cycle after it, from the output register
// the transfer that ends a burst runs the mean division, scale, saturation, the dust-slope
// division and emit, using two passes of the shared radix-2 divider (mean, then dust slope)
// throughput: one transfer per cycle while the result register drains, none during a burst end
// reset: asynchronous, restores register defaults, idle phase and min/max of 1000/2500 mV
module dust_sensor_pulse_average_convert
  import dspac_pkg::*;
#(
  parameter int unsigned ADC_BITS   = 12,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dspac_chan_if.sink   in_i,
  dspac_chan_if.source out_o,
  dspac_chan_if.sink   cfg_i
);

  dspac_cmd_t cmd;
  dspac_sts_t sts;

  dspac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dspac_datapath #(
    .ADC_BITS   (ADC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

/* design/dspac_div.sv */
module dspac_div #(
  parameter int unsigned N_W = 28,
  parameter int unsigned D_W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(N_W);
  localparam logic [CntW-1:0] CntLast = CntW'(N_W - 1);

  logic [N_W-1:0]  quo_q;
  logic [D_W-1:0]  rem_q;
  logic [D_W-1:0]  div_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [D_W:0]    rem_sh;
  logic [D_W:0]    diff;
  logic            fits;

  assign rem_sh = {rem_q, quo_q[N_W-1]};
  assign diff   = rem_sh - {1'b0, div_q};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= diff[D_W-1:0];
        quo_q <= {quo_q[N_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[D_W-1:0];
        quo_q <= {quo_q[N_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/dspac_ctrl.sv */
module dspac_ctrl
  import dspac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dspac_sts_t sts_i,
  output dspac_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    C_IDLE       = 8'b0000_0001,
    C_MEAN_START = 8'b0000_0010,
    C_MEAN_WAIT  = 8'b0000_0100,
    C_SCALE      = 8'b0000_1000,
    C_SAT        = 8'b0001_0000,
    C_DUST_START = 8'b0010_0000,
    C_DUST_WAIT  = 8'b0100_0000,
    C_EMIT       = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign in_ready_o = (state_q == C_IDLE) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      C_IDLE: begin
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept && sts_i.finish) begin
          state_d = C_MEAN_START;
        end
      end
      C_MEAN_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = C_MEAN_WAIT;
      end
      C_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_mean = 1'b1;
          state_d          = C_SCALE;
        end
      end
      C_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = C_SAT;
      end
      C_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = C_DUST_START;
      end
      C_DUST_START: begin
        cmd_o.div_start    = 1'b1;
        cmd_o.div_sel_dust = 1'b1;
        state_d            = C_DUST_WAIT;
      end
      C_DUST_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_dust = 1'b1;
          state_d          = C_EMIT;
        end
      end
      C_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_finish_starts_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && sts_i.finish |=> state_q == C_MEAN_START)
    else $error("burst end did not start the mean division");

  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_EMIT |=> state_q == C_IDLE && !in_ready_o || state_q == C_IDLE)
    else $error("emit did not return to idle");

  a_no_ready_while_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !in_ready_o)
    else $error("input ready while the divider is being started");

endmodule

/* design/dspac_datapath.sv */
module dspac_datapath
  import dspac_pkg::*;
#(
  parameter int unsigned ADC_BITS   = 12,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dspac_cmd_t cmd_i,
  output dspac_sts_t sts_o,
  input  dspac_in_t  in_data_i,
  input  logic       cfg_valid_i,
  input  dspac_cfg_t cfg_data_i,
  output logic       cfg_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dspac_out_t out_data_o
);

  localparam int unsigned SumW    = ADC_BITS + COUNT_BITS;
  localparam int unsigned NumW    = (SumW > DUST_NUM_W) ? SumW : DUST_NUM_W;
  localparam int unsigned DenW    = (COUNT_BITS > MV_W) ? COUNT_BITS : MV_W;
  localparam int unsigned PrW     = ADC_BITS + GAIN_W;
  localparam int unsigned MvFullW = PrW - Q_SHIFT;
  localparam int unsigned V1W     = MV_W + 1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } phase_e;

  logic [TICK_W-1:0] led_delay_q;
  logic [TICK_W-1:0] period_q;
  logic [GAIN_W-1:0] gain_q;

  phase_e            phase_q, phase_d;
  logic              led_q, led_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [COUNT_BITS-1:0] left_q, left_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [SumW-1:0]   raw_q, raw_d;

  logic [MV_W-1:0]     lowest_q;
  logic [MV_W-1:0]     highest_q;
  logic [ADC_BITS-1:0] last_mean_q;
  logic [MV_W-1:0]     last_volt_q;
  logic [DUST_W-1:0]   last_dust_q;
  logic [PrW-1:0]      prod_q;
  logic [DUST_W-1:0]   dust_fixed_q, dust_fixed;
  logic                use_div_q, use_div;

  logic                out_valid_q;
  dspac_out_t          out_q;

  logic [TICK_W-1:0]     on_ticks;
  logic [TICK_W-1:0]     off_ticks;
  logic [ADC_BITS-1:0]   adc_m;
  logic [COUNT_BITS-1:0] cnt_m;
  logic                  finish;

  logic [MvFullW-1:0]    mv_full;
  logic [MV_W-1:0]       volt_sat;

  logic [V1W-1:0]        v1_ext;
  logic [MV_W-1:0]       v2;
  logic [MV_W-1:0]       lower_diff;
  logic [MV_W-1:0]       upper_diff;
  logic [DUST_W-1:0]     up_scaled;
  logic [DUST_NUM_W-1:0] dust_num;
  logic [MV_W-1:0]       dust_den;

  logic [NumW-1:0]       div_dividend;
  logic [DenW-1:0]       div_divisor;
  logic [NumW-1:0]       div_quo;
  logic                  div_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_delay_q <= LED_DELAY_RST;
      period_q    <= PERIOD_RST;
      gain_q      <= GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_data_i.index)
        CFG_LED_DELAY: led_delay_q <= cfg_data_i.wdata[TICK_W-1:0];
        CFG_PERIOD:    period_q    <= cfg_data_i.wdata[TICK_W-1:0];
        CFG_GAIN:      gain_q      <= cfg_data_i.wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // burst sequencing on each input transfer
  assign on_ticks  = (led_delay_q == '0) ? TICK_W'(1) : led_delay_q;
  assign off_ticks = (period_q > led_delay_q) ? period_q - led_delay_q : TICK_W'(1);
  assign adc_m     = ADC_BITS'(in_data_i.adc_raw);
  assign cnt_m     = COUNT_BITS'(in_data_i.sample_count);
  assign finish    = !in_data_i.req_type && (phase_q == PH_ON) &&
                     (tick_q == TICK_W'(1)) && (left_q == COUNT_BITS'(1));

  always_comb begin
    phase_d = phase_q;
    led_d   = led_q;
    tick_d  = tick_q;
    left_d  = left_q;
    total_d = total_q;
    raw_d   = raw_q;
    if (in_data_i.req_type) begin
      if (cnt_m != '0) begin
        raw_d   = '0;
        total_d = cnt_m;
        left_d  = cnt_m;
        led_d   = 1'b1;
        tick_d  = on_ticks;
        phase_d = PH_ON;
      end
    end else begin
      case (phase_q)
        PH_ON: begin
          tick_d = tick_q - TICK_W'(1);
          if (tick_d == '0) begin
            raw_d  = raw_q + SumW'(adc_m);
            led_d  = 1'b0;
            left_d = left_q - COUNT_BITS'(1);
            if (left_d != '0) begin
              phase_d = PH_OFF;
              tick_d  = off_ticks;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
        PH_OFF: begin
          tick_d = tick_q - TICK_W'(1);
          if (tick_d == '0) begin
            led_d   = 1'b1;
            tick_d  = on_ticks;
            phase_d = PH_ON;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      led_q   <= 1'b0;
      tick_q  <= '0;
      left_q  <= '0;
      total_q <= '0;
      raw_q   <= '0;
    end else if (cmd_i.accept) begin
      phase_q <= phase_d;
      led_q   <= led_d;
      tick_q  <= tick_d;
      left_q  <= left_d;
      total_q <= total_d;
      raw_q   <= raw_d;
    end
  end

  // end of burst: mean, scale, min/max, dust map
  assign mv_full  = prod_q[PrW-1:Q_SHIFT];
  assign volt_sat = (mv_full > MvFullW'(MV_MAX)) ? MV_MAX : MV_W'(mv_full);

  assign v1_ext     = {1'b0, lowest_q} + V1W'(V1_OFS);
  assign v2         = highest_q - V2_OFS;
  assign lower_diff = last_volt_q - v1_ext[MV_W-1:0];
  assign upper_diff = last_volt_q - v2;
  assign up_scaled  = DUST_W'(upper_diff) * DUST_UP_MUL;
  assign dust_num   = DUST_NUM_W'(lower_diff) * DUST_NUM_W'(DUST_MID);
  assign dust_den   = v2 - v1_ext[MV_W-1:0];

  always_comb begin
    use_div    = 1'b0;
    dust_fixed = '0;
    if ({1'b0, last_volt_q} < v1_ext) begin
      dust_fixed = '0;
    end else if (last_volt_q < v2) begin
      use_div = 1'b1;
    end else if (last_volt_q < highest_q) begin
      dust_fixed = DUST_MID + (up_scaled >> 1);
    end else begin
      dust_fixed = DUST_MAX;
    end
  end

  assign div_dividend = cmd_i.div_sel_dust ? NumW'(dust_num) : NumW'(raw_q);
  assign div_divisor  = cmd_i.div_sel_dust ? DenW'(dust_den) : DenW'(total_q);

  dspac_div #(
    .N_W (NumW),
    .D_W (DenW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q    <= MIN_MV_RST;
      highest_q   <= MAX_MV_RST;
      last_mean_q <= '0;
      last_volt_q <= '0;
      last_dust_q <= '0;
    end else begin
      if (cmd_i.latch_mean) begin
        last_mean_q <= ADC_BITS'(div_quo);
      end
      if (cmd_i.sat) begin
        last_volt_q <= volt_sat;
        if (volt_sat < lowest_q) begin
          lowest_q <= volt_sat;
        end
        if (volt_sat > highest_q) begin
          highest_q <= volt_sat;
        end
      end
      if (cmd_i.latch_dust) begin
        last_dust_q <= use_div_q ? DUST_W'(div_quo) : dust_fixed_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      prod_q <= PrW'(last_mean_q) * PrW'(gain_q);
    end
    if (cmd_i.div_start && cmd_i.div_sel_dust) begin
      use_div_q    <= use_div;
      dust_fixed_q <= dust_fixed;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.accept && !finish) || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !finish) begin
      out_q.led_on     <= led_d;
      out_q.busy_res   <= phase_d != PH_IDLE;
      out_q.done_res   <= 1'b0;
      out_q.mean_raw   <= MEAN_OUT_W'(last_mean_q);
      out_q.volt_mv    <= last_volt_q;
      out_q.dust_level <= last_dust_q;
      out_q.min_mv     <= lowest_q;
      out_q.max_mv     <= highest_q;
    end else if (cmd_i.emit) begin
      out_q.led_on     <= led_q;
      out_q.busy_res   <= phase_q != PH_IDLE;
      out_q.done_res   <= 1'b1;
      out_q.mean_raw   <= MEAN_OUT_W'(last_mean_q);
      out_q.volt_mv    <= last_volt_q;
      out_q.dust_level <= last_dust_q;
      out_q.min_mv     <= lowest_q;
      out_q.max_mv     <= highest_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.finish   = finish;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.div_done = div_done;

  a_min_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lowest_q <= MIN_MV_RST && highest_q >= MAX_MV_RST)
    else $error("running min or max left its reset bound");

  a_led_off_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> !led_q)
    else $error("led on outside a burst");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && out_q.done_res && !out_q.busy_res)
    else $error("burst end result not flagged correctly");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import dspac_pkg::*;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 5000;

  typedef enum logic [1:0] {
    BURST_IDLE,
    BURST_LED_ON,
    BURST_LED_OFF
  } burst_phase_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    dspac_in_t            item;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] wdata;
    bit                   typed;
    dspac_out_t           want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  dspac_chan_if #(.T(dspac_in_t))  in_if ();
  dspac_chan_if #(.T(dspac_out_t)) out_if ();
  dspac_chan_if #(.T(dspac_cfg_t)) cfg_if ();

  dust_sensor_pulse_average_convert u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // sensor predictor state
  logic [TICK_W-1:0]     cur_led_delay = LED_DELAY_RST;
  logic [TICK_W-1:0]     cur_period    = PERIOD_RST;
  logic [GAIN_W-1:0]     cur_gain      = GAIN_RST;
  burst_phase_e          bphase        = BURST_IDLE;
  logic                  led_lvl       = 1'b0;
  logic [TICK_W-1:0]     ticks_to_go   = '0;
  logic [CNT_IN_W-1:0]   pulses_to_go  = '0;
  logic [CNT_IN_W-1:0]   pulses_in_burst = '0;
  longint unsigned       adc_sum       = 0;
  logic [MV_W-1:0]       floor_mv      = MIN_MV_RST;
  logic [MV_W-1:0]       peak_mv       = MAX_MV_RST;
  logic [MEAN_OUT_W-1:0] mean_hold     = '0;
  logic [MV_W-1:0]       volt_hold     = '0;
  logic [DUST_W-1:0]     dust_hold     = '0;

  dspac_out_t  pending_readings[$];
  plan_row_t   plan[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 0;
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned readings_seen  = 0;
  int unsigned bursts_done    = 0;
  int unsigned regs_written   = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [TICK_W-1:0] on_len();
    return (cur_led_delay == 0) ? TICK_W'(1) : cur_led_delay;
  endfunction

  function automatic dspac_out_t advance_sensor(dspac_in_t it);
    dspac_out_t r;
    bit         done;
    longint     mean;
    longint     mv;
    longint     lo1;
    longint     hi2;
    longint     top;
    longint     dv;
    done = 0;
    if (it.req_type == REQ_START) begin
      if (it.sample_count != 0) begin
        adc_sum         = 0;
        pulses_in_burst = it.sample_count;
        pulses_to_go    = it.sample_count;
        led_lvl         = 1'b1;
        ticks_to_go     = on_len();
        bphase          = BURST_LED_ON;
      end
    end else if (bphase == BURST_LED_ON) begin
      ticks_to_go = ticks_to_go - 1'b1;
      if (ticks_to_go == 0) begin
        adc_sum      = adc_sum + it.adc_raw;
        led_lvl      = 1'b0;
        pulses_to_go = pulses_to_go - 1'b1;
        if (pulses_to_go != 0) begin
          bphase      = BURST_LED_OFF;
          ticks_to_go = (cur_period > cur_led_delay) ? cur_period - cur_led_delay
                                                     : TICK_W'(1);
        end else begin
          bphase = BURST_IDLE;
          done   = 1;
          mean   = (pulses_in_burst != 0) ? longint'(adc_sum / pulses_in_burst) : 0;
          mv     = (mean * longint'(cur_gain)) >>> Q_SHIFT;
          if (mv > longint'(MV_MAX)) mv = MV_MAX;
          mean_hold = MEAN_OUT_W'(mean);
          volt_hold = MV_W'(mv);
          if (volt_hold < floor_mv) floor_mv = volt_hold;
          if (volt_hold > peak_mv) peak_mv = volt_hold;
          // two-segment map from min+50 to max-200 and on from max-200 to the max, capped at the max
          dv  = volt_hold;
          top = peak_mv;
          lo1 = longint'(floor_mv) + V1_OFS;
          hi2 = top - V2_OFS;
          if (dv < lo1) dust_hold = '0;
          else if (dv < hi2) dust_hold = DUST_W'((DUST_MID * (dv - lo1)) / (hi2 - lo1));
          else if (dv < top) dust_hold = DUST_W'(DUST_MID + (300 * (dv - hi2)) / (top - hi2));
          else dust_hold = DUST_MAX;
        end
      end
    end else if (bphase == BURST_LED_OFF) begin
      ticks_to_go = ticks_to_go - 1'b1;
      if (ticks_to_go == 0) begin
        led_lvl     = 1'b1;
        ticks_to_go = on_len();
        bphase      = BURST_LED_ON;
      end
    end
    r.led_on     = led_lvl;
    r.busy_res   = (bphase != BURST_IDLE);
    r.done_res   = done;
    r.mean_raw   = mean_hold;
    r.volt_mv    = volt_hold;
    r.dust_level = dust_hold;
    r.min_mv     = floor_mv;
    r.max_mv     = peak_mv;
    return r;
  endfunction

  function automatic dspac_in_t next_request();
    dspac_in_t   it;
    int unsigned roll;
    roll            = $urandom_range(0, 99);
    it.req_type     = REQ_TICK;
    it.sample_count = CNT_IN_W'($urandom);
    it.adc_raw      = ADC_IN_W'($urandom);
    if (bphase == BURST_IDLE) begin
      if (roll < 70) begin
        it.req_type     = REQ_START;
        it.sample_count = CNT_IN_W'($urandom_range(1, 3));
      end else if (roll < 82) begin
        it.req_type = REQ_START;
      end else if (roll < 88) begin
        it.req_type     = REQ_START;
        it.sample_count = '0;
      end
    end else if (roll < 4) begin
      it.req_type     = REQ_START;
      it.sample_count = CNT_IN_W'($urandom_range(1, 3));
    end
    return it;
  endfunction

  function automatic plan_row_t item_row(logic req, int unsigned cnt, int unsigned adc);
    plan_row_t r;
    r                   = '{kind: ROW_ITEM, default: '0};
    r.item.req_type     = req;
    r.item.sample_count = CNT_IN_W'(cnt);
    r.item.adc_raw      = ADC_IN_W'(adc);
    return r;
  endfunction

  function automatic plan_row_t checked_row(logic req, int unsigned cnt, int unsigned adc,
                                            dspac_out_t want);
    plan_row_t r;
    r       = item_row(req, cnt, adc);
    r.typed = 1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    plan_row_t r;
    r       = '{kind: ROW_CFG, default: '0};
    r.idx   = idx;
    r.wdata = CFG_DATA_W'(data);
    return r;
  endfunction

  task automatic send_item(dspac_in_t it, bit typed, dspac_out_t want);
    int unsigned gap;
    dspac_out_t  pred;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pred = advance_sensor(it);
    pending_readings.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_LED_DELAY: cur_led_delay = data[TICK_W-1:0];
      CFG_PERIOD:    cur_period    = data[TICK_W-1:0];
      CFG_GAIN:      cur_gain      = data[GAIN_W-1:0];
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic run_phase(int unsigned delay, int unsigned period, int unsigned gain,
                           idle_mode_e mode, int unsigned n_items, bit stress);
    write_reg(CFG_LED_DELAY, CFG_DATA_W'(delay));
    write_reg(CFG_PERIOD, CFG_DATA_W'(period));
    write_reg(CFG_GAIN, CFG_DATA_W'(gain));
    send_idle_pct  = (mode == IDLE_SEND) ? 76 : (mode == IDLE_BOTH) ? 33 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 76 : (mode == IDLE_BOTH) ? 33 : 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (stress && i == 20) hold_request = 1;
      if (stress && i == n_items / 2) wait_drained();
      send_item(next_request(), 0, '0);
    end
  endtask

  // reading monitor
  initial begin
    dspac_out_t got;
    dspac_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = out_if.data;
        readings_seen++;
        if (got.done_res) bursts_done++;
        if (pending_readings.size() == 0) begin
          $error("reading with no expectation: %p", got);
          fail_count++;
        end else begin
          want = pending_readings.pop_front();
          if (got.led_on !== want.led_on) begin
            $error("led_on: expected %0d, got %0d", want.led_on, got.led_on);
            fail_count++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            fail_count++;
          end
          if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
            fail_count++;
          end
          if (got.mean_raw !== want.mean_raw) begin
            $error("mean_raw: expected %0d, got %0d", want.mean_raw, got.mean_raw);
            fail_count++;
          end
          if (got.volt_mv !== want.volt_mv) begin
            $error("volt_mv: expected %0d, got %0d", want.volt_mv, got.volt_mv);
            fail_count++;
          end
          if (got.dust_level !== want.dust_level) begin
            $error("dust_level: expected %0d, got %0d", want.dust_level, got.dust_level);
            fail_count++;
          end
          if (got.min_mv !== want.min_mv) begin
            $error("min_mv: expected %0d, got %0d", want.min_mv, got.min_mv);
            fail_count++;
          end
          if (got.max_mv !== want.max_mv) begin
            $error("max_mv: expected %0d, got %0d", want.max_mv, got.max_mv);
            fail_count++;
          end
        end
      end
    end
  end

  // result-side ready, with an optional long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d readings pending", quiet,
                 pending_readings.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    dspac_out_t idle_rst;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;

    idle_rst = '{led_on: 1'b0, busy_res: 1'b0, done_res: 1'b0, mean_raw: '0, volt_mv: '0,
                 dust_level: '0, min_mv: MIN_MV_RST, max_mv: MAX_MV_RST};

    // tick while idle and a zero-count start leave the reset values
    plan.push_back(checked_row(REQ_TICK, 0, 0, idle_rst));
    plan.push_back(checked_row(REQ_START, 0, 4095, idle_rst));
    // full-scale sample at maximum gain saturates and pins the dust at its cap
    plan.push_back(cfg_row(CFG_LED_DELAY, 1));
    plan.push_back(cfg_row(CFG_PERIOD, 2));
    plan.push_back(cfg_row(CFG_GAIN, 4194303));
    plan.push_back(item_row(REQ_START, 1, 0));
    plan.push_back(checked_row(REQ_TICK, 65535, 4095,
      '{led_on: 1'b0, busy_res: 1'b0, done_res: 1'b1, mean_raw: 12'd4095, volt_mv: MV_MAX,
        dust_level: DUST_MAX, min_mv: MIN_MV_RST, max_mv: MV_MAX}));
    // zero gain drives the minimum to zero and the dust below the first knee
    plan.push_back(cfg_row(CFG_GAIN, 0));
    plan.push_back(item_row(REQ_START, 1, 0));
    plan.push_back(checked_row(REQ_TICK, 0, 0,
      '{led_on: 1'b0, busy_res: 1'b0, done_res: 1'b1, mean_raw: '0, volt_mv: '0,
        dust_level: '0, min_mv: '0, max_mv: MV_MAX}));
    // zero delay counts as one tick, period not above delay gives a one-tick off wait
    plan.push_back(cfg_row(CFG_LED_DELAY, 0));
    plan.push_back(cfg_row(CFG_PERIOD, 0));
    plan.push_back(item_row(REQ_START, 2, 0));
    plan.push_back(item_row(REQ_TICK, 0, 4095));
    plan.push_back(item_row(REQ_TICK, 0, 4095));
    plan.push_back(item_row(REQ_TICK, 0, 0));
    // restart while busy, then a normal two-pulse burst
    plan.push_back(cfg_row(CFG_GAIN, GAIN_RST));
    plan.push_back(cfg_row(CFG_LED_DELAY, 2));
    plan.push_back(cfg_row(CFG_PERIOD, 5));
    plan.push_back(item_row(REQ_START, 65535, 0));
    plan.push_back(item_row(REQ_TICK, 0, 4095));
    plan.push_back(item_row(REQ_START, 1, 0));
    plan.push_back(item_row(REQ_TICK, 65535, 0));
    plan.push_back(item_row(REQ_TICK, 0, 2500));
    plan.push_back(item_row(REQ_TICK, 0, 1234));
    plan.push_back(item_row(REQ_START, 2, 0));
    plan.push_back(item_row(REQ_TICK, 0, 7));
    plan.push_back(item_row(REQ_TICK, 0, 100));
    plan.push_back(item_row(REQ_TICK, 0, 0));
    plan.push_back(item_row(REQ_TICK, 0, 0));
    plan.push_back(item_row(REQ_TICK, 0, 0));
    plan.push_back(item_row(REQ_TICK, 0, 0));
    plan.push_back(item_row(REQ_TICK, 0, 3900));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].idx, plan[i].wdata);
      else
        send_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    run_phase(1, 2, GAIN_RST, IDLE_NONE, 200, 0);
    run_phase(3, 7, $urandom_range(0, 4194303), IDLE_SEND, 150, 0);
    run_phase(0, 0, 4194303, IDLE_RECV, 150, 0);
    run_phase(2, 1, $urandom_range(40000, 140000), IDLE_BOTH, 150, 0);
    run_phase(5, 9, GAIN_RST, IDLE_NONE, 150, 1);
    run_phase(65535, 65535, $urandom_range(0, 4194303), IDLE_BOTH, 60, 0);
    run_phase(1, 65535, $urandom_range(20000, 90000), IDLE_NONE, 200, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d items, %0d readings, %0d finished bursts, %0d register writes",
             items_sent, readings_seen, bursts_done, regs_written);
    $display("settings spanned zero and full-scale delay, period and gain, with idle and stall mixes");
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
